### rtl/ddo_pkg.sv
// Shared types, constants and helper functions of the differential-drive odometry block.
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // iterative multiplier: a times b, b taken one 16-bit digit a cycle
  localparam int unsigned MUL_AW   = 81;
  localparam int unsigned MUL_BW   = 48;
  localparam int unsigned MUL_DW   = 16;
  localparam int unsigned MUL_PW   = MUL_AW + MUL_BW;
  localparam int unsigned MUL_NDIG = MUL_BW / MUL_DW;

  // iterative divider: restoring, a few quotient bits a cycle
  localparam int unsigned DIV_NW    = 81;
  localparam int unsigned DIV_DW    = 24;
  localparam int unsigned DIV_BPC   = 3;
  localparam int unsigned DIV_NSTEP = DIV_NW / DIV_BPC;

  localparam int unsigned CW = 34;

  localparam logic [21:0]        WHEEL_DIAM_RST = 22'd200000;
  localparam logic [23:0]        AXLE_LEN_RST   = 24'd500000;
  localparam logic [DIV_DW-1:0]  US_PER_2S      = 24'd2000000;
  localparam logic [MUL_BW-1:0]  W_SCALE        = 48'd15625;
  localparam logic [MUL_BW-1:0]  HEAD_K         = 48'd192406520023;
  localparam logic signed [CW-1:0] CORDIC_X0    = 34'sd652032874;

  localparam logic REG_WHEEL_DIAM = 1'b0;
  localparam logic REG_AXLE_LEN   = 1'b1;

  typedef struct packed {
    logic        first;
    logic [47:0] stamp;
    logic        sum_neg;
    logic [32:0] sum_mag;
    logic        dif_neg;
    logic [32:0] dif_mag;
  } ddo_item_t;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } ddo_mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } ddo_div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_V, ST_W1, ST_W2, ST_WD, ST_DT, ST_DM, ST_DD,
    ST_HM1, ST_HM2, ST_COR, ST_XM, ST_YM, ST_OUT
  } ddo_state_e;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      5'd24:   r = 32'd41;
      5'd25:   r = 32'd20;
      5'd26:   r = 32'd10;
      5'd27:   r = 32'd5;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      5'd30:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // sign and magnitude to saturated 32-bit two's complement
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m);
    logic [31:0] r;
    if (neg) begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(~m + 64'd1);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic [65:0] v);
    logic [47:0] r;
    if ((&v[65:47]) || !(|v[65:47])) begin
      r = v[47:0];
    end else if (v[65]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/ddo_front.sv
// Input side: accepts items, derives wheel sum and difference, queues them for the back end.
module ddo_front import ddo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] left_wheel_speed_i,
  input  logic [31:0] right_wheel_speed_i,
  input  logic [47:0] stamp_us_i,
  output logic        q_valid_o,
  output ddo_item_t   q_item_o,
  input  logic        q_pop_i
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  ddo_item_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            first_q, first_d;
  logic            push;
  logic [32:0]     sum, dif;
  ddo_item_t       item;

  assign in_stall_o = (cnt_q == NW'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    sum = {left_wheel_speed_i[31], left_wheel_speed_i}
        + {right_wheel_speed_i[31], right_wheel_speed_i};
    dif = {right_wheel_speed_i[31], right_wheel_speed_i}
        - {left_wheel_speed_i[31], left_wheel_speed_i};
    item.first   = first_q;
    item.stamp   = stamp_us_i;
    item.sum_neg = sum[32];
    item.sum_mag = sum[32] ? (33'd0 - sum) : sum;
    item.dif_neg = dif[32];
    item.dif_mag = dif[32] ? (33'd0 - dif) : dif;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    first_d  = first_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      first_d  = 1'b0;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      first_q  <= 1'b1;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

### rtl/ddo_mul.sv
// Iterative unsigned multiplier, one 16-bit digit of the second operand per cycle.
module ddo_mul import ddo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddo_mul_req_t      req_i,
  output logic              done_o,
  output logic [MUL_PW-1:0] p_o
);

  localparam int unsigned CNTW = (MUL_NDIG > 1) ? $clog2(MUL_NDIG) : 1;

  logic [MUL_AW-1:0]        a_q;
  logic [MUL_BW-1:0]        b_q;
  logic [MUL_PW-1:0]        acc_q, acc_d;
  logic [MUL_AW+MUL_DW-1:0] prod;
  logic [CNTW-1:0]          cnt_q;
  logic                     busy_q, done_q;

  assign done_o = done_q;
  assign p_o    = acc_q;

  always_comb begin
    prod  = a_q * b_q[MUL_BW-1 -: MUL_DW];
    acc_d = (acc_q << MUL_DW) + MUL_PW'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(MUL_NDIG - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_q << MUL_DW;
    end
  end

endmodule

### rtl/ddo_div.sv
// Iterative restoring divider, a few quotient bits per cycle.
module ddo_div import ddo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddo_div_req_t      req_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] q_o
);

  localparam int unsigned CNTW = $clog2(DIV_NSTEP);

  logic [DIV_NW-1:0] n_q, n_n;
  logic [DIV_DW-1:0] r_q, r_n, d_q;
  logic [DIV_DW:0]   t;
  logic [CNTW-1:0]   cnt_q;
  logic              busy_q, done_q;

  assign done_o = done_q;
  assign q_o    = n_q;

  // numerator shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    r_n = r_q;
    n_n = n_q;
    t   = '0;
    for (int k = 0; k < DIV_BPC; k++) begin
      t   = {r_n, n_n[DIV_NW-1]};
      n_n = {n_n[DIV_NW-2:0], 1'b0};
      if (t >= {1'b0, d_q}) begin
        r_n    = DIV_DW'(t - {1'b0, d_q});
        n_n[0] = 1'b1;
      end else begin
        r_n = t[DIV_DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(DIV_NSTEP - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q <= req_i.n;
      d_q <= req_i.d;
      r_q <= '0;
    end else if (busy_q) begin
      n_q <= n_n;
      r_q <= r_n;
    end
  end

endmodule

### rtl/ddo_cordic.sv
// Iterative CORDIC: cos and sin in Q1.30 of a 32-bit binary angle, one rotation per cycle.
module ddo_cordic import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          ang_i,
  output logic                 done_o,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam int unsigned IW = $clog2(CORDIC_STEPS);

  logic signed [CW-1:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [31:0]   z_q, z_d;
  logic [31:0]          at;
  logic [1:0]           quad_q;
  logic [IW-1:0]        cnt_q;
  logic                 busy_q, done_q;

  assign done_o = done_q;

  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    at = atan_lut(5'(cnt_q));
    if (!z_q[31]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - $signed(at);
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + $signed(at);
    end
  end

  // exact quarter-turn rotation by the top angle bits
  always_comb begin
    case (quad_q)
      2'd0: begin cos_o = x_q;  sin_o = y_q;  end
      2'd1: begin cos_o = -y_q; sin_o = x_q;  end
      2'd2: begin cos_o = -x_q; sin_o = -y_q; end
      default: begin cos_o = y_q; sin_o = -x_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == IW'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= {2'b00, ang_i[29:0]};
      quad_q <= ang_i[31:30];
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

endmodule

### rtl/ddo_back.sv
// Back end: speeds; past the first item also time step, heading step, CORDIC, position.
module ddo_back import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [21:0] wheel_diam_i,
  input  logic [23:0] axle_len_i,
  input  logic        q_valid_i,
  input  ddo_item_t   q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] pos_x_um_o,
  output logic [47:0] pos_y_um_o,
  output logic [31:0] heading_o,
  output logic [31:0] linear_speed_o,
  output logic [31:0] turn_rate_o,
  output logic        pose_updated_o
);

  ddo_state_e state_q, state_d;

  ddo_mul_req_t      mul_req;
  ddo_div_req_t      div_req;
  logic              mul_done, div_done, cor_done, cor_start;
  logic [MUL_PW-1:0] mul_p;
  logic [DIV_NW-1:0] div_q;
  logic [31:0]       cor_ang;
  logic signed [CW-1:0] cor_cos, cor_sin;

  // model state
  logic [47:0] last_stamp_q, pos_x_q, pos_y_q;
  logic [31:0] last_v_q, last_w_q, heading_q;

  // per-item working registers
  logic [31:0] v_q, w_q, dphi_q;
  logic [47:0] tm_q;
  logic [32:0] wm_q;
  logic [60:0] dist_q;
  logic [CW-1:0] smag_q;
  logic        dneg_q, hneg_q, cneg_q, sneg_q;

  // output register
  logic        out_valid_q, out_load, can_load;
  logic [47:0] ox_q, oy_q;
  logic [31:0] oh_q, ov_q, ow_q;
  logic        oupd_q;

  logic [23:0] axle_eff;
  logic [47:0] raw, tm_c;
  logic        tneg_c;
  logic [32:0] vs_c, ws_c, vm_c, wm_c;
  logic [31:0] dphi_c, half_c;
  logic [CW-1:0] cmag_c, smag_c;
  logic [63:0] pm_c;
  logic [65:0] dx_c, sum_c;
  logic        xneg_c;

  ddo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .q_o    (div_q)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ang_i   (cor_ang),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  assign can_load = !out_valid_q || !out_stall_i;
  assign axle_eff = (axle_len_i == '0) ? 24'd1 : axle_len_i;

  // time step, speed sums, heading step, CORDIC magnitudes and position step
  always_comb begin
    raw    = q_item_i.stamp - last_stamp_q;
    tneg_c = raw[47];
    tm_c   = tneg_c ? (48'd0 - raw) : raw;
    vs_c   = {v_q[31], v_q} + {last_v_q[31], last_v_q};
    ws_c   = {w_q[31], w_q} + {last_w_q[31], last_w_q};
    vm_c   = vs_c[32] ? (33'd0 - vs_c) : vs_c;
    wm_c   = ws_c[32] ? (33'd0 - ws_c) : ws_c;
    dphi_c = hneg_q ? (32'd0 - mul_p[80:49]) : mul_p[80:49];
    half_c = hneg_q ? (32'd0 - mul_p[81:50]) : mul_p[81:50];
    cmag_c = cor_cos[CW-1] ? CW'(-cor_cos) : CW'(cor_cos);
    smag_c = cor_sin[CW-1] ? CW'(-cor_sin) : CW'(cor_sin);
    // position step: trunc(dist * f / 2^30) with its sign
    pm_c   = mul_p[93:30];
    xneg_c = (state_q == ST_XM) ? (dneg_q ^ cneg_q) : (dneg_q ^ sneg_q);
    dx_c   = xneg_c ? (66'd0 - {2'b00, pm_c}) : {2'b00, pm_c};
    sum_c  = ((state_q == ST_XM) ? {{18{pos_x_q[47]}}, pos_x_q} : {{18{pos_y_q[47]}}, pos_y_q})
           + dx_c;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_V;
      ST_V:    if (mul_done) state_d = ST_W1;
      ST_W1:   if (mul_done) state_d = ST_W2;
      ST_W2:   if (mul_done) state_d = ST_WD;
      ST_WD:   if (div_done) state_d = q_item_i.first ? ST_OUT : ST_DT;
      ST_DT:   state_d = ST_DM;
      ST_DM:   if (mul_done) state_d = ST_DD;
      ST_DD:   if (div_done) state_d = ST_HM1;
      ST_HM1:  if (mul_done) state_d = ST_HM2;
      ST_HM2:  if (mul_done) state_d = ST_COR;
      ST_COR:  if (cor_done) state_d = ST_XM;
      ST_XM:   if (mul_done) state_d = ST_YM;
      ST_YM:   if (mul_done) state_d = ST_OUT;
      ST_OUT:  if (can_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_req   = '0;
    div_req   = '0;
    cor_start = 1'b0;
    cor_ang   = q_item_i.first ? heading_q : heading_q + half_c;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        mul_req.start = q_valid_i;
        mul_req.a     = MUL_AW'(q_item_i.sum_mag);
        mul_req.b     = MUL_BW'(wheel_diam_i);
      end
      ST_V: begin
        mul_req.start = mul_done;
        mul_req.a     = MUL_AW'(q_item_i.dif_mag);
        mul_req.b     = MUL_BW'(wheel_diam_i);
      end
      ST_W1: begin
        mul_req.start = mul_done;
        mul_req.a     = mul_p[MUL_AW-1:0];
        mul_req.b     = W_SCALE;
      end
      ST_W2: begin
        div_req.start = mul_done;
        div_req.n     = mul_p[DIV_NW-1:0];
        div_req.d     = axle_eff;
      end
      ST_DT: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(vm_c);
        mul_req.b     = tm_c;
      end
      ST_DM: begin
        div_req.start = mul_done;
        div_req.n     = mul_p[DIV_NW-1:0];
        div_req.d     = US_PER_2S;
      end
      ST_DD: begin
        mul_req.start = div_done;
        mul_req.a     = MUL_AW'(wm_q);
        mul_req.b     = tm_q;
      end
      ST_HM1: begin
        mul_req.start = mul_done;
        mul_req.a     = mul_p[MUL_AW-1:0];
        mul_req.b     = HEAD_K;
      end
      ST_HM2: cor_start = mul_done;
      ST_COR: begin
        mul_req.start = cor_done;
        mul_req.a     = MUL_AW'(dist_q);
        mul_req.b     = MUL_BW'(cmag_c);
      end
      ST_XM: begin
        mul_req.start = mul_done;
        mul_req.a     = MUL_AW'(dist_q);
        mul_req.b     = MUL_BW'(smag_q);
      end
      ST_OUT: begin
        q_pop_o  = can_load;
        out_load = can_load;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_stamp_q <= '0;
      last_v_q     <= '0;
      last_w_q     <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      heading_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_XM && mul_done) begin
        pos_x_q <= sat48(sum_c);
      end
      if (state_q == ST_YM && mul_done) begin
        pos_y_q   <= sat48(sum_c);
        heading_q <= heading_q + dphi_q;
      end
      if (out_load) begin
        last_stamp_q <= q_item_i.stamp;
        last_v_q     <= v_q;
        last_w_q     <= w_q;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_V && mul_done) begin
      v_q <= sat32(q_item_i.sum_neg, mul_p[81:18]);
    end
    if (state_q == ST_WD && div_done) begin
      w_q <= sat32(q_item_i.dif_neg, div_q[74:11]);
    end
    if (state_q == ST_DT) begin
      tm_q   <= tm_c;
      wm_q   <= wm_c;
      dneg_q <= vs_c[32] ^ tneg_c;
      hneg_q <= ws_c[32] ^ tneg_c;
    end
    if (state_q == ST_DD && div_done) begin
      dist_q <= div_q[60:0];
    end
    if (state_q == ST_HM2 && mul_done) begin
      dphi_q <= dphi_c;
    end
    if (state_q == ST_COR && cor_done) begin
      cneg_q <= cor_cos[CW-1];
      sneg_q <= cor_sin[CW-1];
      smag_q <= smag_c;
    end
    if (out_load) begin
      ox_q   <= pos_x_q;
      oy_q   <= pos_y_q;
      oh_q   <= heading_q;
      ov_q   <= v_q;
      ow_q   <= w_q;
      oupd_q <= !q_item_i.first;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_um_o     = ox_q;
  assign pos_y_um_o     = oy_q;
  assign heading_o      = oh_q;
  assign linear_speed_o = ov_q;
  assign turn_rate_o    = ow_q;
  assign pose_updated_o = oupd_q;

endmodule

### rtl/diff_drive_odometry.sv
// Top level of the differential-drive odometry block: register port, front end and back end.
//
// Each item (left and right wheel speed in Q16.16 rad/s, stamp in us) gives one result:
// pose (x, y in um, 48-bit saturating; heading as a 32-bit wrapping binary angle), the
// item's forward speed in um/s and yaw rate in urad/s, and pose_updated, which is 0 for the
// first item after reset. From the second item on the pose is integrated by the midpoint
// rule over the stamp difference. A later item makes eight passes through a multiplier
// that takes 16 bits of one operand a cycle, two passes through a divider that makes 3
// quotient bits a cycle and one CORDIC pass of one rotation a cycle; the first item
// makes only three multiplier passes and one divider pass. A two-item queue sits between
// input and back end, and a finished result waits in the output register while the next
// item is worked on. Registers: wheel diameter at address 0, axle length at address 4;
// write them only while the block is idle.
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] left_wheel_speed_i,
  input  logic [31:0] right_wheel_speed_i,
  input  logic [47:0] stamp_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] pos_x_um_o,
  output logic [47:0] pos_y_um_o,
  output logic [31:0] heading_o,
  output logic [31:0] linear_speed_o,
  output logic [31:0] turn_rate_o,
  output logic        pose_updated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [21:0] wheel_diam_q;
  logic [23:0] axle_len_q;
  logic        q_valid, q_pop;
  ddo_item_t   q_item;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_diam_q <= WHEEL_DIAM_RST;
      axle_len_q   <= AXLE_LEN_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WHEEL_DIAM: wheel_diam_q <= pwdata[21:0];
        REG_AXLE_LEN:   axle_len_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WHEEL_DIAM: prdata = 32'(wheel_diam_q);
      REG_AXLE_LEN:   prdata = 32'(axle_len_q);
      default:        prdata = '0;
    endcase
  end

  ddo_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .left_wheel_speed_i  (left_wheel_speed_i),
    .right_wheel_speed_i (right_wheel_speed_i),
    .stamp_us_i          (stamp_us_i),
    .q_valid_o           (q_valid),
    .q_item_o            (q_item),
    .q_pop_i             (q_pop)
  );

  ddo_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wheel_diam_i   (wheel_diam_q),
    .axle_len_i     (axle_len_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pos_x_um_o     (pos_x_um_o),
    .pos_y_um_o     (pos_y_um_o),
    .heading_o      (heading_o),
    .linear_speed_o (linear_speed_o),
    .turn_rate_o    (turn_rate_o),
    .pose_updated_o (pose_updated_o)
  );

  // the back end only retires an item the queue holds
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a result without pose update is the first item: the pose is still at the origin
  a_first_at_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pose_updated_o) |->
      (pos_x_um_o == '0 && pos_y_um_o == '0 && heading_o == '0))
    else $error("non-integrated result with moved pose");

  // a result is never produced while the queue and back end have nothing to report
  a_result_from_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop))
    else $error("result appeared without a retired item");

endmodule
